// ----- src/vda_pkg.sv -----
// ---------------------------------------------------------------------------
// vda_pkg
// Shared types and constants for the vector distance accumulator: metric
// codes and binary32 bit patterns used by the float units and the top.
// ---------------------------------------------------------------------------
`default_nettype none

package vda_pkg;

  // metric register codes; the fourth code is unused and adds nothing
  typedef enum logic [1:0] {
    METRIC_L2  = 2'd0,
    METRIC_DOT = 2'd1,
    METRIC_L1  = 2'd2
  } metric_t;

  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;
  localparam logic [7:0]  EXP_ONES  = 8'hFF;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;

endpackage

`default_nettype wire

// ----- src/vda_fadd.sv -----
// ---------------------------------------------------------------------------
// vda_fadd
// Combinational binary32 adder, round to nearest even, subnormals kept.
// Any NaN result is the canonical quiet NaN.
// ---------------------------------------------------------------------------
`default_nettype none

module vda_fadd import vda_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        a_nan, b_nan, a_inf, b_inf;
  logic        swap;
  logic [31:0] big, lit;
  logic [7:0]  e_big, e_lit, dexp;
  logic [4:0]  dsh;
  logic [26:0] m_big, m_lit, m_lit_sh;
  logic        sticky_al;
  logic        eff_sub;
  logic [27:0] sum;
  logic [4:0]  lz;
  logic [7:0]  lsh;
  logic [26:0] norm;
  logic [9:0]  e_res;
  logic [7:0]  exp_field;
  logic [30:0] packed_v, rounded;
  logic        rnd_up;
  logic        sign_res;

  // operand classes
  assign a_nan = (a[30:23] == EXP_ONES) && (a[22:0] != '0);
  assign b_nan = (b[30:23] == EXP_ONES) && (b[22:0] != '0);
  assign a_inf = (a[30:23] == EXP_ONES) && (a[22:0] == '0);
  assign b_inf = (b[30:23] == EXP_ONES) && (b[22:0] == '0);

  // order by magnitude
  assign swap = a[30:0] < b[30:0];
  assign big  = swap ? b : a;
  assign lit  = swap ? a : b;

  assign e_big = (big[30:23] == '0) ? 8'd1 : big[30:23];
  assign e_lit = (lit[30:23] == '0) ? 8'd1 : lit[30:23];
  assign m_big = {big[30:23] != '0, big[22:0], 3'b000};
  assign m_lit = {lit[30:23] != '0, lit[22:0], 3'b000};

  // align smaller operand, keep sticky
  assign dexp = e_big - e_lit;
  assign dsh  = (dexp > 8'd26) ? 5'd27 : dexp[4:0];
  assign sticky_al = |(m_lit & ~({27{1'b1}} << dsh));
  assign m_lit_sh  = (m_lit >> dsh) | {26'd0, sticky_al};

  assign eff_sub = a[31] ^ b[31];
  assign sum = eff_sub ? ({1'b0, m_big} - {1'b0, m_lit_sh})
                       : ({1'b0, m_big} + {1'b0, m_lit_sh});

  // leading zero count, highest set bit wins
  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) begin
        lz = 5'(26 - i);
      end
    end
  end

  // normalize, stop at the subnormal boundary
  always_comb begin
    lsh = 8'd0;
    if (sum[27]) begin
      norm  = {sum[27:2], sum[1] | sum[0]};
      e_res = {2'b00, e_big} + 10'd1;
    end else begin
      lsh   = ({3'b000, lz} < (e_big - 8'd1)) ? {3'b000, lz} : (e_big - 8'd1);
      norm  = sum[26:0] << lsh;
      e_res = {2'b00, e_big} - {2'b00, lsh};
    end
  end

  // round on the packed word so carries reach the exponent
  assign exp_field = norm[26] ? e_res[7:0] : 8'd0;
  assign packed_v  = {exp_field, norm[25:3]};
  assign rnd_up    = norm[2] & (norm[1] | norm[0] | norm[3]);
  assign rounded   = packed_v + {30'd0, rnd_up};

  assign sign_res = (sum == '0) ? (a[31] & b[31]) : big[31];

  // special cases and result
  always_comb begin
    if (a_nan || b_nan || (a_inf && b_inf && eff_sub)) begin
      y = QNAN;
    end else if (a_inf) begin
      y = a;
    end else if (b_inf) begin
      y = b;
    end else if (e_res >= 10'd255) begin
      y = {sign_res, EXP_ONES, 23'd0};
    end else begin
      y = {sign_res, rounded};
    end
  end

endmodule

`default_nettype wire

// ----- src/vda_fmul.sv -----
// ---------------------------------------------------------------------------
// vda_fmul
// Combinational binary32 multiplier, round to nearest even, subnormals
// kept. Any NaN result is the canonical quiet NaN.
// ---------------------------------------------------------------------------
`default_nettype none

module vda_fmul import vda_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic               sign_res;
  logic [7:0]         ea, eb;
  logic [23:0]        ma, mb;
  logic [47:0]        prod;
  logic [5:0]         lz;
  logic signed [10:0] e_pre;
  logic signed [10:0] rs_full;
  logic [5:0]         rs;
  logic [47:0]        p_norm, shv;
  logic               st;
  logic [7:0]         exp_field;
  logic [30:0]        packed_v, rounded;
  logic               rnd_up, sticky;

  // operand classes
  assign a_nan  = (a[30:23] == EXP_ONES) && (a[22:0] != '0);
  assign b_nan  = (b[30:23] == EXP_ONES) && (b[22:0] != '0);
  assign a_inf  = (a[30:23] == EXP_ONES) && (a[22:0] == '0);
  assign b_inf  = (b[30:23] == EXP_ONES) && (b[22:0] == '0);
  assign a_zero = (a[30:0] == '0);
  assign b_zero = (b[30:0] == '0);
  assign sign_res = a[31] ^ b[31];

  assign ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
  assign eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
  assign ma = {a[30:23] != '0, a[22:0]};
  assign mb = {b[30:23] != '0, b[22:0]};

  // significand product
  assign prod = ma * mb;

  // leading zero count of the product
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod[i]) begin
        lz = 6'(47 - i);
      end
    end
  end

  assign e_pre = $signed({3'b000, ea}) + $signed({3'b000, eb})
               - $signed(11'd126) - $signed({5'b00000, lz});

  // normalize, then shift right into the subnormal range if needed
  assign p_norm  = prod << lz;
  assign rs_full = $signed(11'd1) - e_pre;
  always_comb begin
    if (e_pre >= $signed(11'd1)) begin
      rs = 6'd0;
    end else if (rs_full > $signed(11'd48)) begin
      rs = 6'd48;
    end else begin
      rs = rs_full[5:0];
    end
  end
  assign st  = |(p_norm & ~({48{1'b1}} << rs));
  assign shv = p_norm >> rs;

  // round on the packed word
  assign exp_field = shv[47] ? e_pre[7:0] : 8'd0;
  assign packed_v  = {exp_field, shv[46:24]};
  assign sticky    = (|shv[22:0]) | st;
  assign rnd_up    = shv[23] & (sticky | shv[24]);
  assign rounded   = packed_v + {30'd0, rnd_up};

  // special cases and result
  always_comb begin
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      y = QNAN;
    end else if (a_inf || b_inf) begin
      y = {sign_res, EXP_ONES, 23'd0};
    end else if (a_zero || b_zero) begin
      y = {sign_res, 31'd0};
    end else if (e_pre >= $signed(11'd255)) begin
      y = {sign_res, EXP_ONES, 23'd0};
    end else begin
      y = {sign_res, rounded};
    end
  end

endmodule

`default_nettype wire

// ----- src/vector_distance_accumulator.sv -----
// ---------------------------------------------------------------------------
// vector_distance_accumulator
// Streams binary32 element pairs and folds the squared difference, the
// product or the absolute difference into one running total; the total is
// emitted and cleared on the last pair of a vector.
// ---------------------------------------------------------------------------
// path: input, difference and term registers, then the result register
// throughput: one pair per cycle unless stalled; the total add is a loop
// input register, difference, multiply and accumulate are separate stages
// input stalls only while a result waits and another last pair is ready
// reset: metric squared euclidean, total positive zero, pipeline empty
`default_nettype none

module vector_distance_accumulator import vda_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        metric_we,
  input  logic [1:0]  metric_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] elem_a,
  input  logic [31:0] elem_b,
  input  logic        last_element,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] distance
);

  logic [1:0]  metric;
  logic        adv;

  logic        v0, last0;
  logic [1:0]  m0;
  logic [31:0] a0, b0;

  logic        v1, last1;
  logic [1:0]  m1;
  logic [31:0] a1, b1, d1;

  logic        v2, last2, use2;
  logic [31:0] term2;

  logic [31:0] total, total_next;
  logic [31:0] diff, prod, mul_a, mul_b, sum;
  logic [31:0] term_next;
  logic        use_next;

  // metric register
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= METRIC_L2;
    end else if (metric_we) begin
      metric <= metric_wdata;
    end
  end

  // pipeline moves unless a new result would overwrite a stalled one
  assign adv      = !(out_valid && out_stall && v2 && last2);
  assign in_stall = !adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a0    <= elem_a;
      b0    <= elem_b;
      last0 <= last_element;
      m0    <= metric;
    end
  end

  // difference a - b
  vda_fadd u_diff (
    .a (a0),
    .b (b0 ^ SIGN_BIT),
    .y (diff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a1    <= a0;
      b1    <= b0;
      d1    <= diff;
      last1 <= last0;
      m1    <= m0;
    end
  end

  // square of difference or product
  assign mul_a = (m1 == METRIC_DOT) ? a1 : d1;
  assign mul_b = (m1 == METRIC_DOT) ? b1 : d1;

  vda_fmul u_mul (
    .a (mul_a),
    .b (mul_b),
    .y (prod)
  );

  // per-pair term select
  always_comb begin
    case (m1)
      METRIC_L2, METRIC_DOT: begin
        term_next = prod;
        use_next  = 1'b1;
      end
      METRIC_L1: begin
        term_next = {1'b0, d1[30:0]};
        use_next  = 1'b1;
      end
      default: begin
        term_next = POS_ZERO;
        use_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      term2 <= term_next;
      use2  <= use_next;
      last2 <= last1;
    end
  end

  // accumulate
  vda_fadd u_acc (
    .a (total),
    .b (term2),
    .y (sum)
  );

  assign total_next = use2 ? sum : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= POS_ZERO;
    end else if (adv && v2) begin
      total <= last2 ? POS_ZERO : total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && v2 && last2) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (adv && v2 && last2) begin
      if ((total_next[30:23] == EXP_ONES) && (total_next[22:0] != '0)) begin
        distance <= QNAN;
      end else begin
        distance <= total_next;
      end
    end
  end

  // checks
  a_total_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && v2 && last2) |=> (total == POS_ZERO))
    else $error("total not cleared after last pair");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (adv && v2 && last2) |=> out_valid)
    else $error("result word not presented");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v2 && last2))
    else $error("input stalled without a pending result");

  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (distance[30:23] == EXP_ONES) && (distance[22:0] != '0))
      |-> (distance == QNAN))
    else $error("non-canonical NaN emitted");

endmodule

`default_nettype wire
